// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies.
package lkvc_pkg;
    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BYTES_DEF = 8;
    localparam int CAP_W           = 5;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;

    typedef struct packed {
        logic load;     // capture request, run the lookup
        logic commit;   // apply state update and present result
    } cmd_t;

    typedef struct packed {
        logic out_busy; // result word not yet taken
    } sts_t;
endpackage

// ===== rtl/lkvc_ctrl.sv =====
// Controller state machine for the LRU key-value cache.
// Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lkvc_pkg::sts_t  sts,
    output lkvc_pkg::cmd_t  cmd
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_ready    = (state_reg == ST_IDLE) && !sts.out_busy;
    assign cmd.load   = s_valid && s_ready;
    assign cmd.commit = (state_reg == ST_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd.load) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/lkvc_datapath.sv =====
// Datapath of the LRU key-value cache: entry store, match, recency, counters.
// Depends on lkvc_pkg.
module lkvc_datapath #(
    parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES   = lkvc_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = lkvc_pkg::VALUE_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lkvc_pkg::cmd_t             cmd,
    output lkvc_pkg::sts_t             sts,
    input  logic                       cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic [2:0]                 s_operation,
    input  logic [8*KEY_BYTES-1:0]     s_key,
    input  logic [3:0]                 s_key_length,
    input  logic [8*VALUE_BYTES-1:0]   s_value,
    input  logic [3:0]                 s_value_length,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [8*VALUE_BYTES-1:0]   m_value_out,
    output logic [3:0]                 m_value_length_out,
    output logic [31:0]                m_hit_count,
    output logic [31:0]                m_miss_count,
    output logic [31:0]                m_eviction_count,
    output logic [$clog2(ENTRIES+1)-1:0] m_occupancy
);
    localparam int KW = 8 * KEY_BYTES;
    localparam int VW = 8 * VALUE_BYTES;
    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int RW = (IW < 1) ? 1 : IW;
    localparam int CW = lkvc_pkg::CAP_W;

    logic [KW-1:0] ekey   [ENTRIES];
    logic [3:0]    eklen  [ENTRIES];
    logic [VW-1:0] evalue [ENTRIES];
    logic [3:0]    evlen  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [RW-1:0] rank_reg [ENTRIES];
    logic [31:0] hits_reg, misses_reg, evict_reg;
    logic [OW-1:0] used_reg;
    logic [CW-1:0] cap_reg;

    // captured request and lookup results
    logic [2:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic [3:0]    klen_reg;
    logic [VW-1:0] val_reg;
    logic [3:0]    vlen_reg;
    logic          hit_reg;
    logic [RW-1:0] hidx_reg;
    logic          free_any_reg;
    logic [RW-1:0] free_idx_reg;
    logic [RW-1:0] old_idx_reg;
    logic          full_reg;

    // clamp lengths and mask unused bytes
    logic [3:0]    klen_c, vlen_c;
    logic [KW-1:0] key_c;
    logic [VW-1:0] val_c;
    always_comb begin
        klen_c = (s_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : s_key_length;
        vlen_c = (s_value_length > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : s_value_length;
        for (int b = 0; b < KEY_BYTES; b++)
            key_c[8*b +: 8] = (4'(b) < klen_c) ? s_key[8*b +: 8] : 8'd0;
        for (int b = 0; b < VALUE_BYTES; b++)
            val_c[8*b +: 8] = (4'(b) < vlen_c) ? s_value[8*b +: 8] : 8'd0;
    end

    // parallel compare, free slot and oldest entry
    logic [ENTRIES-1:0] match;
    logic          hit_c, free_c;
    logic [RW-1:0] hidx_c, fidx_c, oidx_c;
    logic [CW-1:0] cap_c;
    always_comb begin
        hit_c = 1'b0; hidx_c = '0; free_c = 1'b0; fidx_c = '0; oidx_c = '0;
        for (int i = 0; i < ENTRIES; i++)
            match[i] = valid_reg[i] && eklen[i] == klen_c && ekey[i] == key_c;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_c = 1'b1; hidx_c = RW'(i);
            end
            if (!valid_reg[i]) begin
                free_c = 1'b1; fidx_c = RW'(i);
            end
            // ranks are distinct, so the oldest is the one ranked used-1
            if (valid_reg[i] && {1'b0, rank_reg[i]} == (RW+1)'(used_reg - 1'b1))
                oidx_c = RW'(i);
        end
        cap_c = (cap_reg == '0) ? CW'(1) :
                (32'(cap_reg) > ENTRIES) ? CW'(ENTRIES) : cap_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_operation; key_reg <= key_c; klen_reg <= klen_c;
            val_reg <= val_c; vlen_reg <= vlen_c;
            hit_reg <= hit_c; hidx_reg <= hidx_c;
            free_any_reg <= free_c; free_idx_reg <= fidx_c; old_idx_reg <= oidx_c;
            full_reg <= 32'(used_reg) >= 32'(cap_c);
        end
    end

    // commit step
    logic is_get, is_put, is_rem, is_clr, do_evict, do_ins;
    logic [RW-1:0] ins_idx, ref_rank;
    always_comb begin
        is_get = cmd.commit && op_reg == lkvc_pkg::OP_GET;
        is_put = cmd.commit && op_reg == lkvc_pkg::OP_PUT;
        is_rem = cmd.commit && op_reg == lkvc_pkg::OP_REMOVE;
        is_clr = cmd.commit && op_reg == lkvc_pkg::OP_CLEAR;
        do_evict = is_put && !hit_reg && full_reg && used_reg != '0;
        // after an eviction the victim slot is free; lowest free wins
        ins_idx  = (do_evict && (!free_any_reg || old_idx_reg < free_idx_reg))
                   ? old_idx_reg : free_idx_reg;
        do_ins   = is_put && !hit_reg && (free_any_reg || do_evict);
        ref_rank = rank_reg[hidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_ins) begin
            ekey[ins_idx] <= key_reg; eklen[ins_idx] <= klen_reg;
            evalue[ins_idx] <= val_reg; evlen[ins_idx] <= vlen_reg;
        end else if (is_put && hit_reg) begin
            evalue[hidx_reg] <= val_reg; evlen[hidx_reg] <= vlen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0; used_reg <= '0;
            hits_reg <= '0; misses_reg <= '0; evict_reg <= '0;
            cap_reg <= CW'(16);
            m_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end else begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.commit) m_valid <= 1'b1;
            if (is_clr) begin
                valid_reg <= '0; used_reg <= '0;
                for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
            end
            if (is_get) begin
                if (hit_reg) hits_reg <= (&hits_reg) ? hits_reg : hits_reg + 1'b1;
                else misses_reg <= (&misses_reg) ? misses_reg : misses_reg + 1'b1;
            end
            // promote to most recent on a hit
            if ((is_get || is_put) && hit_reg) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i] && RW'(i) != hidx_reg && rank_reg[i] < ref_rank)
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                rank_reg[hidx_reg] <= '0;
            end
            if (is_rem && hit_reg) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i] && rank_reg[i] > ref_rank)
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                rank_reg[hidx_reg] <= '0;
                valid_reg[hidx_reg] <= 1'b0;
                used_reg <= used_reg - 1'b1;
            end
            if (is_put && !hit_reg) begin
                // victim is the oldest, so all others simply age by one
                if (do_evict) begin
                    evict_reg <= (&evict_reg) ? evict_reg : evict_reg + 1'b1;
                    valid_reg[old_idx_reg] <= 1'b0;
                end
                if (do_ins) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (valid_reg[i]) rank_reg[i] <= rank_reg[i] + 1'b1;
                    rank_reg[ins_idx] <= '0;
                    valid_reg[ins_idx] <= 1'b1;
                    used_reg <= do_evict ? used_reg : used_reg + 1'b1;
                end else if (do_evict) begin
                    used_reg <= used_reg - 1'b1;
                end
            end
        end
    end

    // result word; counters sampled after the update
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_found            <= is_get && hit_reg;
            m_value_out        <= (is_get && hit_reg) ? evalue[hidx_reg] : '0;
            m_value_length_out <= (is_get && hit_reg) ? evlen[hidx_reg] : 4'd0;
        end
    end

    assign m_hit_count      = hits_reg;
    assign m_miss_count     = misses_reg;
    assign m_eviction_count = evict_reg;
    assign m_occupancy      = used_reg;
    assign sts.out_busy     = m_valid;
endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
//  channel   ports      carries
//  request   s_*        one request word: operation, key, lengths, value
//  result    m_*        one result word: hit, value, counters, occupancy
//  config    cfg_*      capacity register, write only
//
// A request is captured and its key compared against every entry in parallel
// in the cycle it is accepted; the next cycle commits recency, entry and
// counter updates and registers the result word. s_ready stays low until the
// cycle after the result word is taken, so a new request is not accepted
// before the last result is taken. Reset empties the store, zeroes the
// counters and sets capacity to 16; there is no clearing pass. A stalled
// result holds the request channel.
module lru_key_value_cache #(
    parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES   = lkvc_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = lkvc_pkg::VALUE_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_operation,
    input  logic [8*KEY_BYTES-1:0]     s_key,
    input  logic [3:0]                 s_key_length,
    input  logic [8*VALUE_BYTES-1:0]   s_value,
    input  logic [3:0]                 s_value_length,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [8*VALUE_BYTES-1:0]   m_value_out,
    output logic [3:0]                 m_value_length_out,
    output logic [31:0]                m_hit_count,
    output logic [31:0]                m_miss_count,
    output logic [31:0]                m_eviction_count,
    output logic [$clog2(ENTRIES+1)-1:0] m_occupancy
);
    lkvc_pkg::cmd_t cmd;
    lkvc_pkg::sts_t sts;

    // sequence capture and commit
    lkvc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    // hold entries, ranks and counters
    lkvc_datapath #(
        .ENTRIES(ENTRIES), .KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_operation(s_operation), .s_key(s_key), .s_key_length(s_key_length),
        .s_value(s_value), .s_value_length(s_value_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_value_out(m_value_out), .m_value_length_out(m_value_length_out),
        .m_hit_count(m_hit_count), .m_miss_count(m_miss_count),
        .m_eviction_count(m_eviction_count), .m_occupancy(m_occupancy)
    );
endmodule
